@@ hdl/imudr_pkg.sv @@
// shared types and constants for the imu dead reckoning unit
`default_nettype none
package imudr_pkg;

  // 32.147 ft/s^2 per g in Q16.16
  localparam logic [21:0] GRAV_Q16 = 22'd2106786;
  localparam logic [9:0]  MS_RESET = 10'd10;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] radial_speed;
    logic signed [31:0] radial_accel;
    logic signed [31:0] position_x;
    logic signed [31:0] velocity_x;
    logic signed [31:0] scaled_accel_x;
    logic signed [31:0] position_y;
    logic signed [31:0] velocity_y;
    logic signed [31:0] scaled_accel_y;
    logic               at_origin;
  } out_word_t;

endpackage
`default_nettype wire

@@ hdl/imu_trapezoid_dead_reckoning_unit.sv @@
// imu dead reckoning: trapezoid integration and radial terms with serial arithmetic
//
// Input words (in_valid/in_stall) carry one two-axis accelerometer sample.
// Each sample is scaled to ft/s^2, integrated into velocity and position and
// turned into radial speed and acceleration; one result word per sample
// leaves on out_valid/out_stall. cfg_we/cfg_data write the sample period (ms).
// All arithmetic runs through three shared bit-serial units: a shift-add
// multiplier, a restoring divider and a digit-by-digit square root, driven
// by a phase sequencer. One sample takes 15 products, 6 divisions and one root,
// or 8 products, 4 divisions and the root when the position is at the origin.
// One sample is processed at a time; in_stall is high while it runs.
// The finished word sits in an output register, so a new sample is taken
// while the previous result waits; a stalled output holds its word and a
// finished computation waits until the register frees up.
// Synchronous reset clears position, velocity and history to zero and sets
// the period to 10 ms.
`default_nettype none
module imu_trapezoid_dead_reckoning_unit
  import imudr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [9:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_SQRT  = 7'b0010000,
    S_WB    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // sequencer phases
  localparam logic [4:0] PH_AX  = 5'd0,  PH_AY  = 5'd1;
  localparam logic [4:0] PH_VXM = 5'd2,  PH_VXD = 5'd3, PH_VYM = 5'd4, PH_VYD = 5'd5;
  localparam logic [4:0] PH_PXM = 5'd6,  PH_PXD = 5'd7, PH_PYM = 5'd8, PH_PYD = 5'd9;
  localparam logic [4:0] PH_SQX = 5'd10, PH_SQY = 5'd11, PH_ROOT = 5'd12;
  localparam logic [4:0] PH_RV0 = 5'd13, PH_RV1 = 5'd14, PH_RVD = 5'd15;
  localparam logic [4:0] PH_RA0 = 5'd16, PH_RA1 = 5'd17, PH_RA2 = 5'd18;
  localparam logic [4:0] PH_RA3 = 5'd19, PH_RA4 = 5'd20, PH_RAD = 5'd21;

  localparam logic [5:0] MUL_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd31;

  state_t state_r, state_nxt;
  logic [4:0]  ph_r, ph_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [9:0]  ms_r, ms_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_r, out_nxt;

  in_word_t    smp_r, smp_nxt;
  logic [31:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [31:0] vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic [31:0] lvel_x_r, lvel_x_nxt, lvel_y_r, lvel_y_nxt;
  logic [31:0] lacc_x_r, lacc_x_nxt, lacc_y_r, lacc_y_nxt;
  logic [31:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [31:0] p_r, p_nxt, rv_r, rv_nxt;
  logic [63:0] pp_r, pp_nxt, nn_r, nn_nxt;
  logic        sgn_r, sgn_nxt, org_r, org_nxt;

  // serial unit registers
  logic [63:0] mcand_r, mcand_nxt, prod_r, prod_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [32:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [63:0] sqv_r, sqv_nxt;
  logic [31:0] root_r, root_nxt;
  logic [33:0] srem_r, srem_nxt;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat35(input logic [34:0] v);
    logic [31:0] r;
    if (!v[34] && (v[33:31] != 3'b000))     r = 32'h7fff_ffff;
    else if (v[34] && (v[33:31] != 3'b111)) r = 32'h8000_0000;
    else                                    r = v[31:0];
    return r;
  endfunction

  // saturate a quotient magnitude with its sign
  function automatic logic [31:0] div_sat(input logic [63:0] q, input logic neg);
    logic [31:0] r;
    if (!neg) r = (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    else      r = (q >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    return r;
  endfunction

  // one step of each serial unit
  logic [33:0] div_sh;
  logic        div_ge;
  logic [35:0] sq_sh, sq_trial;
  logic        sq_ge;
  assign div_sh   = {rem_r, dvd_r[63]};
  assign div_ge   = div_sh >= {1'b0, dvs_r};
  assign sq_sh    = {srem_r, sqv_r[63:62]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // sums feeding the integration products
  logic [32:0] sum_s, sum_mag;
  logic [31:0] sum_a, sum_b;
  always_comb begin
    case (ph_r)
      PH_VXM:  begin sum_a = lacc_x_r; sum_b = ax_r;    end
      PH_VYM:  begin sum_a = lacc_y_r; sum_b = ay_r;    end
      PH_PXM:  begin sum_a = lvel_x_r; sum_b = vel_x_r; end
      default: begin sum_a = lvel_y_r; sum_b = vel_y_r; end
    endcase
    sum_s   = {sum_a[31], sum_a} + {sum_b[31], sum_b};
    sum_mag = sum_s[32] ? (33'd0 - sum_s) : sum_s;
  end

  // rounded quotient and scaled sample results
  logic [34:0] dq, upd;
  logic [31:0] upd_base;
  logic [63:0] rnd;
  logic [31:0] rnd_s;
  logic [63:0] diff;
  always_comb begin
    dq = sgn_r ? (35'd0 - {1'b0, dvd_r[33:0]}) : {1'b0, dvd_r[33:0]};
    case (ph_r)
      PH_VXD:  upd_base = vel_x_r;
      PH_VYD:  upd_base = vel_y_r;
      PH_PXD:  upd_base = pos_x_r;
      default: upd_base = pos_y_r;
    endcase
    upd   = {{3{upd_base[31]}}, upd_base} + dq;
    rnd   = (prod_r + 64'd2048) >> 12;
    rnd_s = sgn_r ? (32'd0 - rnd[31:0]) : rnd[31:0];
    diff  = (pp_r >= nn_r) ? (pp_r - nn_r) : (nn_r - pp_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; cnt_nxt = cnt_r;
    ms_nxt = cfg_we ? cfg_data : ms_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    smp_nxt = smp_r;
    pos_x_nxt = pos_x_r; pos_y_nxt = pos_y_r; vel_x_nxt = vel_x_r; vel_y_nxt = vel_y_r;
    lvel_x_nxt = lvel_x_r; lvel_y_nxt = lvel_y_r; lacc_x_nxt = lacc_x_r; lacc_y_nxt = lacc_y_r;
    ax_nxt = ax_r; ay_nxt = ay_r; p_nxt = p_r; rv_nxt = rv_r;
    pp_nxt = pp_r; nn_nxt = nn_r; sgn_nxt = sgn_r; org_nxt = org_r;
    mcand_nxt = mcand_r; prod_nxt = prod_r; mplier_nxt = mplier_r;
    dvd_nxt = dvd_r; rem_nxt = rem_r; dvs_nxt = dvs_r;
    sqv_nxt = sqv_r; root_nxt = root_r; srem_nxt = srem_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smp_nxt   = in_data;
          ph_nxt    = PH_AX;
          state_nxt = S_SETUP;
        end
      end

      S_SETUP: begin
        cnt_nxt  = 6'd0;
        prod_nxt = 64'd0;
        rem_nxt  = 33'd0;
        case (ph_r)
          PH_AX, PH_AY: begin
            mcand_nxt  = {32'd0, mag32({{16{smp_r.accel_x[15]}}, smp_r.accel_x})};
            sgn_nxt    = smp_r.accel_x[15];
            if (ph_r == PH_AY) begin
              mcand_nxt = {32'd0, mag32({{16{smp_r.accel_y[15]}}, smp_r.accel_y})};
              sgn_nxt   = smp_r.accel_y[15];
            end
            mplier_nxt = {10'd0, GRAV_Q16};
            state_nxt  = S_MUL;
          end
          PH_VXM, PH_VYM, PH_PXM, PH_PYM: begin
            mcand_nxt  = {31'd0, sum_mag};
            mplier_nxt = {22'd0, ms_r};
            sgn_nxt    = sum_s[32];
            state_nxt  = S_MUL;
          end
          PH_VXD, PH_VYD, PH_PXD, PH_PYD: begin
            dvd_nxt   = prod_r + 64'd1000;
            dvs_nxt   = 33'd2000;
            state_nxt = S_DIV;
          end
          PH_SQX: begin
            mcand_nxt = {32'd0, mag32(pos_x_r)}; mplier_nxt = mag32(pos_x_r);
            state_nxt = S_MUL;
          end
          PH_SQY: begin
            mcand_nxt = {32'd0, mag32(pos_y_r)}; mplier_nxt = mag32(pos_y_r);
            state_nxt = S_MUL;
          end
          PH_ROOT: begin
            sqv_nxt = pp_r; root_nxt = 32'd0; srem_nxt = 34'd0;
            state_nxt = S_SQRT;
          end
          PH_RV0: begin
            mcand_nxt = {32'd0, mag32(pos_x_r)}; mplier_nxt = mag32(vel_x_r);
            sgn_nxt = pos_x_r[31] ^ vel_x_r[31]; state_nxt = S_MUL;
          end
          PH_RV1: begin
            mcand_nxt = {32'd0, mag32(pos_y_r)}; mplier_nxt = mag32(vel_y_r);
            sgn_nxt = pos_y_r[31] ^ vel_y_r[31]; state_nxt = S_MUL;
          end
          PH_RA0: begin
            mcand_nxt = {32'd0, mag32(vel_x_r)}; mplier_nxt = mag32(vel_x_r);
            sgn_nxt = 1'b0; state_nxt = S_MUL;
          end
          PH_RA1: begin
            mcand_nxt = {32'd0, mag32(vel_y_r)}; mplier_nxt = mag32(vel_y_r);
            sgn_nxt = 1'b0; state_nxt = S_MUL;
          end
          PH_RA2: begin
            mcand_nxt = {32'd0, mag32(pos_x_r)}; mplier_nxt = mag32(ax_r);
            sgn_nxt = pos_x_r[31] ^ ax_r[31]; state_nxt = S_MUL;
          end
          PH_RA3: begin
            mcand_nxt = {32'd0, mag32(pos_y_r)}; mplier_nxt = mag32(ay_r);
            sgn_nxt = pos_y_r[31] ^ ay_r[31]; state_nxt = S_MUL;
          end
          PH_RA4: begin
            mcand_nxt = {32'd0, mag32(rv_r)}; mplier_nxt = mag32(rv_r);
            sgn_nxt = 1'b1; state_nxt = S_MUL;
          end
          default: begin
            // radial divisions
            dvd_nxt   = diff;
            dvs_nxt   = {1'b0, p_r};
            sgn_nxt   = pp_r < nn_r;
            state_nxt = S_DIV;
          end
        endcase
      end

      // shift-add multiplier, one multiplier bit per cycle
      S_MUL: begin
        if (mplier_r[0]) prod_nxt = prod_r + mcand_r;
        mcand_nxt  = {mcand_r[62:0], 1'b0};
        mplier_nxt = {1'b0, mplier_r[31:1]};
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == MUL_LAST) state_nxt = S_WB;
      end

      // restoring divider, one quotient bit per cycle
      S_DIV: begin
        rem_nxt = div_ge ? (div_sh[32:0] - dvs_r) : div_sh[32:0];
        dvd_nxt = {dvd_r[62:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) state_nxt = S_WB;
      end

      // square root, one root bit per cycle
      S_SQRT: begin
        srem_nxt = sq_ge ? (sq_sh[33:0] - sq_trial[33:0]) : sq_sh[33:0];
        root_nxt = {root_r[30:0], sq_ge};
        sqv_nxt  = {sqv_r[61:0], 2'b00};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == SQRT_LAST) state_nxt = S_WB;
      end

      S_WB: begin
        ph_nxt    = ph_r + 5'd1;
        state_nxt = S_SETUP;
        case (ph_r)
          PH_AX:  ax_nxt = rnd_s;
          PH_AY:  ay_nxt = rnd_s;
          PH_VXD: begin vel_x_nxt = sat35(upd); lacc_x_nxt = ax_r; end
          PH_VYD: begin vel_y_nxt = sat35(upd); lacc_y_nxt = ay_r; end
          PH_PXD: begin pos_x_nxt = sat35(upd); lvel_x_nxt = vel_x_r; end
          PH_PYD: begin pos_y_nxt = sat35(upd); lvel_y_nxt = vel_y_r; end
          PH_SQX: pp_nxt = prod_r;
          PH_SQY: pp_nxt = pp_r + prod_r;
          PH_ROOT: begin
            p_nxt   = root_r;
            org_nxt = (root_r == 32'd0);
            if (root_r == 32'd0) begin
              rv_nxt    = 32'd0;
              state_nxt = S_DONE;
            end
          end
          PH_RV0, PH_RA0: begin
            pp_nxt = sgn_r ? 64'd0 : prod_r;
            nn_nxt = sgn_r ? prod_r : 64'd0;
          end
          PH_RVD: rv_nxt = div_sat(dvd_r, sgn_r);
          PH_RAD: state_nxt = S_DONE;
          default: begin
            // accumulate into the positive or negative sum
            if (sgn_r) nn_nxt = nn_r + prod_r;
            else       pp_nxt = pp_r + prod_r;
          end
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.radial_speed   = rv_r;
          out_nxt.radial_accel   = org_r ? 32'd0 : div_sat(dvd_r, sgn_r);
          out_nxt.position_x     = pos_x_r;
          out_nxt.velocity_x     = vel_x_r;
          out_nxt.scaled_accel_x = ax_r;
          out_nxt.position_y     = pos_y_r;
          out_nxt.velocity_y     = vel_y_r;
          out_nxt.scaled_accel_y = ay_r;
          out_nxt.at_origin      = org_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ph_r <= PH_AX; cnt_r <= 6'd0; ms_r <= MS_RESET;
      out_valid_r <= 1'b0;
      pos_x_r <= 32'd0; pos_y_r <= 32'd0; vel_x_r <= 32'd0; vel_y_r <= 32'd0;
      lvel_x_r <= 32'd0; lvel_y_r <= 32'd0; lacc_x_r <= 32'd0; lacc_y_r <= 32'd0;
    end else begin
      state_r <= state_nxt; ph_r <= ph_nxt; cnt_r <= cnt_nxt; ms_r <= ms_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r <= pos_x_nxt; pos_y_r <= pos_y_nxt; vel_x_r <= vel_x_nxt; vel_y_r <= vel_y_nxt;
      lvel_x_r <= lvel_x_nxt; lvel_y_r <= lvel_y_nxt;
      lacc_x_r <= lacc_x_nxt; lacc_y_r <= lacc_y_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt; smp_r <= smp_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; p_r <= p_nxt; rv_r <= rv_nxt;
    pp_r <= pp_nxt; nn_r <= nn_nxt; sgn_r <= sgn_nxt; org_r <= org_nxt;
    mcand_r <= mcand_nxt; prod_r <= prod_nxt; mplier_r <= mplier_nxt;
    dvd_r <= dvd_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
    sqv_r <= sqv_nxt; root_r <= root_nxt; srem_r <= srem_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ tb/tb_dr_checker.sv @@
// checker for the imu dead reckoning unit: predicts and compares result words
`timescale 1ns / 1ps
module tb_dr_checker
  import imudr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         origin_seen
);

  // predicted model state
  logic [9:0]         period_ms;
  logic signed [31:0] px, py, vx, vy, lvx, lvy, lax, lay;
  out_word_t          expected_q[$];

  assign pending = expected_q.size();

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // round to nearest, ties away from zero
  function automatic logic signed [63:0] round_div(logic signed [63:0] n, longint d);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // signed 128-bit sum divided by p, truncated, saturated
  function automatic logic signed [31:0] radial_quot(logic signed [127:0] num, logic [63:0] p);
    logic signed [127:0] q;
    q = num / $signed({64'd0, p});
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic out_word_t predict_sample(in_word_t w);
    out_word_t           r;
    logic signed [63:0]  ms, ax, ay;
    logic [63:0]         p;
    logic signed [127:0] num;
    ms = {54'd0, period_ms};
    ax = round_div(64'(w.accel_x) * 64'sd2106786, 4096);
    ay = round_div(64'(w.accel_y) * 64'sd2106786, 4096);
    vx = sat32(64'(vx) + round_div(ms * (64'(lax) + ax), 2000));
    vy = sat32(64'(vy) + round_div(ms * (64'(lay) + ay), 2000));
    lax = ax[31:0];
    lay = ay[31:0];
    px = sat32(64'(px) + round_div(ms * (64'(lvx) + 64'(vx)), 2000));
    py = sat32(64'(py) + round_div(ms * (64'(lvy) + 64'(vy)), 2000));
    lvx = vx;
    lvy = vy;
    p = isqrt(64'(64'(px) * 64'(px)) + 64'(64'(py) * 64'(py)));
    r = '0;
    r.at_origin = (p == 0);
    if (p != 0) begin
      num = 128'(px) * 128'(vx) + 128'(py) * 128'(vy);
      r.radial_speed = radial_quot(num, p);
      num = 128'(vx) * 128'(vx) + 128'(vy) * 128'(vy) + 128'(px) * 128'(ax)
          + 128'(py) * 128'(ay) - 128'(r.radial_speed) * 128'(r.radial_speed);
      r.radial_accel = radial_quot(num, p);
    end
    r.position_x = px;
    r.velocity_x = vx;
    r.scaled_accel_x = ax[31:0];
    r.position_y = py;
    r.velocity_y = vy;
    r.scaled_accel_y = ay[31:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      period_ms <= MS_RESET;
      {px, py, vx, vy, lvx, lvy, lax, lay} = '0;
      expected_q.delete();
      fail_count <= 0;
      origin_seen <= 0;
    end else begin
      if (cfg_we) period_ms <= cfg_data;
      if (in_valid && !in_stall) expected_q.push_back(predict_sample(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with no expectation");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (e.at_origin) origin_seen <= origin_seen + 1;
          check_field("radial_speed", e.radial_speed, out_data.radial_speed);
          check_field("radial_accel", e.radial_accel, out_data.radial_accel);
          check_field("position_x", e.position_x, out_data.position_x);
          check_field("velocity_x", e.velocity_x, out_data.velocity_x);
          check_field("scaled_accel_x", e.scaled_accel_x, out_data.scaled_accel_x);
          check_field("position_y", e.position_y, out_data.position_y);
          check_field("velocity_y", e.velocity_y, out_data.velocity_y);
          check_field("scaled_accel_y", e.scaled_accel_y, out_data.scaled_accel_y);
          check_field("at_origin", 32'(e.at_origin), 32'(out_data.at_origin));
        end
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
// top of the imu dead reckoning testbench: clock, reset, stimulus, verdict
`timescale 1ns / 1ps
module tb_top;
  import imudr_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_data;
  logic       cfg_we;
  logic [9:0] cfg_data;
  int         fail_count;
  int         pending;
  int         origin_seen;
  int         sent;

  imu_trapezoid_dead_reckoning_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  tb_dr_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .origin_seen(origin_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 1500);
  endfunction

  // receiver stall pattern
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(50, 1500)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  task automatic send_word(logic [15:0] ax, logic [15:0] ay);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{accel_x: ax, accel_y: ay};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_period(logic [9:0] ms);
    drain();
    repeat (1100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= ms;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random accel: mostly small values, some full scale
  function automatic logic [15:0] rand_accel();
    if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 1023)) - 512);
    return 16'($urandom);
  endfunction

  initial begin
    logic [9:0] periods[6];
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    sent = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: zero input keeps the unit at the origin, then extremes
    send_word(16'h0000, 16'h0000);
    send_word(16'h0000, 16'h0000);
    send_word(16'h7fff, 16'h8000);
    send_word(16'h8000, 16'h7fff);
    send_word(16'hffff, 16'h0001);
    send_word(16'h0001, 16'hffff);
    send_word(16'h5555, 16'haaaa);
    send_word(16'haaaa, 16'h5555);
    // zero period leaves motion frozen
    write_period(10'd0);
    send_word(16'h7fff, 16'h7fff);
    send_word(16'h8000, 16'h8000);
    // largest period drives saturation
    write_period(10'd1023);
    repeat (8) send_word(16'h7fff, 16'h7fff);
    repeat (8) send_word(16'h8000, 16'h8000);
    // random phases over several periods
    periods = '{10'd1, 10'd10, 10'd1000, 10'd1023, 10'd0, 10'd37};
    foreach (periods[i]) begin
      write_period(periods[i]);
      repeat (125) send_word(rand_accel(), rand_accel());
    end
    drain();
    repeat (1200) @(posedge clk);
    $display("sent %0d sample words over six period settings incl. 0 and 1023", sent);
    $display("origin results seen: %0d", origin_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #300ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
hdl/imudr_pkg.sv
hdl/imu_trapezoid_dead_reckoning_unit.sv
tb/tb_dr_checker.sv
tb/tb_top.sv
